// ===== hw/rtl/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared widths, constants and types for the touch sample calibration block.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int COEF_W     = 32;
  localparam int RAW_W      = 10;
  localparam int Z_W        = 15;
  localparam int TIME_W     = 32;
  localparam int DELAY_W    = 16;
  localparam int POS_W      = 16;
  localparam int PRES_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // pressure window, exclusive at both ends
  localparam int MIN_PRESSURE = 10;
  localparam int MAX_PRESSURE = 1000;

  // affine datapath
  localparam int SCALE       = 10000;
  localparam int ROUND       = 5000;
  localparam int PROD_W      = COEF_W + RAW_W + 1;   // 32b signed x 11b signed
  localparam int SUM_W       = PROD_W + 1;           // two products plus offset
  localparam int MAG_W       = 29;                   // |sum| below the saturation limit
  localparam int RECIP_SHIFT = MAG_W + 14;           // exact for MAG_W bit dividends
  localparam int RECIP_W     = 30;
  localparam int SCALED_W    = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SCALE) - 64'd1) / 64'(SCALE));
  localparam logic signed [SUM_W-1:0] SAT_LIMIT = SUM_W'(SCALE * 32768);
  localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7fff;
  localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;

  // pressure arithmetic
  localparam int PCALC_W = PRES_W + 1;
  localparam logic signed [PCALC_W-1:0] PRES_HI = PCALC_W'(65535);
  localparam logic signed [PCALC_W-1:0] PRES_LO = -PCALC_W'(32768);

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_E        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_F        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RESIST    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY = 3'd7;

  // event kinds
  localparam logic EV_DOWN = 1'b0;
  localparam logic EV_UP   = 1'b1;

  // pipeline depth from input register to output register
  localparam int NUM_STAGES = 6;

  typedef struct packed {
    logic signed [COEF_W-1:0] w_x;
    logic signed [COEF_W-1:0] w_y;
    logic signed [COEF_W-1:0] offset;
  } affine_coef_t;

  typedef struct packed {
    logic                      down;
    logic                      up;
    logic signed [PRES_W-1:0]  pressure;
  } touch_dec_t;

  typedef struct packed {
    logic mul;
    logic sum;
    logic abs;
    logic div;
  } pipe_en_t;

endpackage

// ===== hw/rtl/tsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsc_ctrl
// Configuration registers, touch state and the per-request down/up decision.
// ----------------------------------------------------------------------------
module tsc_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 accept,
  input  logic [tsc_pkg::Z_W-1:0]              raw_z,
  input  logic [tsc_pkg::TIME_W-1:0]           now_ms,
  output tsc_pkg::affine_coef_t                coef_x,
  output tsc_pkg::affine_coef_t                coef_y,
  output tsc_pkg::touch_dec_t                  dec
);
  import tsc_pkg::*;

  logic [Z_W-1:0]     min_resistance;
  logic [DELAY_W-1:0] release_delay_ms;
  logic               touching;
  logic [TIME_W-1:0]  last_touch_ms;
  logic [TIME_W-1:0]  elapsed;
  logic signed [PCALC_W-1:0] pres_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x.w_x       <= COEF_W'(SCALE);
      coef_x.w_y       <= '0;
      coef_x.offset    <= '0;
      coef_y.w_x       <= '0;
      coef_y.w_y       <= COEF_W'(SCALE);
      coef_y.offset    <= '0;
      min_resistance   <= '0;
      release_delay_ms <= DELAY_W'(50);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COEF_A:        coef_x.w_x       <= cfg_data;
        REG_COEF_B:        coef_x.w_y       <= cfg_data;
        REG_COEF_C:        coef_x.offset    <= cfg_data;
        REG_COEF_D:        coef_y.w_x       <= cfg_data;
        REG_COEF_E:        coef_y.w_y       <= cfg_data;
        REG_COEF_F:        coef_y.offset    <= cfg_data;
        REG_MIN_RESIST:    min_resistance   <= cfg_data[Z_W-1:0];
        REG_RELEASE_DELAY: release_delay_ms <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // elapsed time wraps modulo 2^32
  assign elapsed = now_ms - last_touch_ms;

  assign pres_raw = PCALC_W'(MAX_PRESSURE) - $signed({3'b000, raw_z})
                    + $signed({3'b000, min_resistance});

  always_comb begin
    dec.down = (raw_z > Z_W'(MIN_PRESSURE)) && (raw_z < Z_W'(MAX_PRESSURE));
    dec.up   = !dec.down && touching && (elapsed >= TIME_W'(release_delay_ms));
    if (pres_raw > PRES_HI) begin
      dec.pressure = PRES_W'(PRES_HI);
    end else if (pres_raw < PRES_LO) begin
      dec.pressure = PRES_W'(PRES_LO);
    end else begin
      dec.pressure = PRES_W'(pres_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touching      <= 1'b0;
      last_touch_ms <= '0;
    end else if (accept) begin
      if (dec.down) begin
        touching      <= 1'b1;
        last_touch_ms <= now_ms;
      end else if (dec.up) begin
        touching      <= 1'b0;
      end
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (rst) !(dec.down && dec.up))
    else $error("touch-down and touch-up decided together");
  a_down: assert property (@(posedge clk) disable iff (rst)
      accept && dec.down |=> touching && last_touch_ms == $past(now_ms))
    else $error("touch-down did not record state");
  a_up: assert property (@(posedge clk) disable iff (rst)
      accept && dec.up |=> !touching)
    else $error("touch-up did not clear touching");
  a_up_needs_touch: assert property (@(posedge clk) disable iff (rst)
      dec.up |-> touching)
    else $error("touch-up while not touching");

endmodule

// ===== hw/rtl/tsc_affine.sv =====
// ----------------------------------------------------------------------------
// tsc_affine
// One calibrated axis: products, sum, magnitude and saturation check,
// reciprocal multiply by 1/10000, then sign restore and clamp.
// ----------------------------------------------------------------------------
module tsc_affine (
  input  logic                               clk,
  input  tsc_pkg::pipe_en_t                  en,
  input  logic [tsc_pkg::RAW_W-1:0]          raw_x,
  input  logic [tsc_pkg::RAW_W-1:0]          raw_y,
  input  tsc_pkg::affine_coef_t              coef,
  output logic signed [tsc_pkg::POS_W-1:0]   pos
);
  import tsc_pkg::*;

  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [SUM_W-1:0]  sum;
  logic                     sat_hi;
  logic                     sat_lo;
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic                     sat_hi_d;
  logic                     sat_lo_d;
  logic                     neg_d;
  logic [SCALED_W-1:0]      scaled;
  logic signed [POS_W-1:0]  quot;

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_x <= PROD_W'(coef.w_x) * PROD_W'($signed({1'b0, raw_x}));
      prod_y <= PROD_W'(coef.w_y) * PROD_W'($signed({1'b0, raw_y}));
    end
    if (en.sum) begin
      sum <= SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(coef.offset) + SUM_W'(ROUND);
    end
    // below the limit the magnitude fits MAG_W bits; above it the flags decide
    if (en.abs) begin
      sat_hi <= sum >= SAT_LIMIT;
      sat_lo <= sum <= -SAT_LIMIT;
      neg    <= sum[SUM_W-1];
      mag    <= sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
    end
    if (en.div) begin
      scaled   <= SCALED_W'(mag) * SCALED_W'(RECIP);
      sat_hi_d <= sat_hi;
      sat_lo_d <= sat_lo;
      neg_d    <= neg;
    end
  end

  assign quot = $signed(scaled[RECIP_SHIFT +: POS_W]);

  // truncate toward zero: divide the magnitude, then restore the sign
  always_comb begin
    if (sat_hi_d) begin
      pos = POS_MAX;
    end else if (sat_lo_d) begin
      pos = POS_MIN;
    end else if (neg_d) begin
      pos = -quot;
    end else begin
      pos = quot;
    end
  end

endmodule

// ===== hw/rtl/touch_sample_calibrate_core.sv =====
// ----------------------------------------------------------------------------
// touch_sample_calibrate_core
// Resistive touch sample calibration: pressure window, affine map, touch-up.
// ----------------------------------------------------------------------------
// One sample request may be accepted every clock cycle. A request that yields
// a touch-down or touch-up result passes six registers (input register,
// product, sum, magnitude, reciprocal multiply, output register); the input
// register loads on the accepting edge; out_valid is the output register's
// valid bit. A request that yields nothing leaves a bubble that later
// results close up. in_ready drops only when all six stages hold results and
// out_ready is low. The touch state is updated at acceptance, so consecutive
// samples see each other's effect without waiting for the pipeline.
module touch_sample_calibrate_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tsc_pkg::RAW_W-1:0]            raw_x,
  input  logic [tsc_pkg::RAW_W-1:0]            raw_y,
  input  logic [tsc_pkg::Z_W-1:0]              raw_z,
  input  logic [tsc_pkg::TIME_W-1:0]           now_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 event_kind,
  output logic signed [tsc_pkg::POS_W-1:0]     pos_x,
  output logic signed [tsc_pkg::POS_W-1:0]     pos_y,
  output logic signed [tsc_pkg::PRES_W-1:0]    pressure
);
  import tsc_pkg::*;

  logic                       accept;
  affine_coef_t               coef_x;
  affine_coef_t               coef_y;
  touch_dec_t                 dec;
  pipe_en_t                   en;
  logic [NUM_STAGES-1:0]      vld;
  logic [NUM_STAGES:0]        adv;
  logic [RAW_W-1:0]           x_in;
  logic [RAW_W-1:0]           y_in;
  logic                       kind_pipe [NUM_STAGES-1];
  logic signed [PRES_W-1:0]   pres_pipe [NUM_STAGES-1];
  logic signed [POS_W-1:0]    calc_x;
  logic signed [POS_W-1:0]    calc_y;

  assign accept = in_valid && in_ready;

  tsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .raw_z     (raw_z),
    .now_ms    (now_ms),
    .coef_x    (coef_x),
    .coef_y    (coef_y),
    .dec       (dec)
  );

  // a stage may load when it is empty or its occupant moves on
  always_comb begin
    adv[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];
  assign en.mul   = adv[1];
  assign en.sum   = adv[2];
  assign en.abs   = adv[3];
  assign en.div   = adv[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid && (dec.down || dec.up);
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x_in         <= raw_x;
      y_in         <= raw_y;
      kind_pipe[0] <= dec.down ? EV_DOWN : EV_UP;
      pres_pipe[0] <= dec.pressure;
    end
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (adv[k]) begin
        kind_pipe[k] <= kind_pipe[k-1];
        pres_pipe[k] <= pres_pipe[k-1];
      end
    end
  end

  tsc_affine u_affine_x (
    .clk   (clk),
    .en    (en),
    .raw_x (x_in),
    .raw_y (y_in),
    .coef  (coef_x),
    .pos   (calc_x)
  );

  tsc_affine u_affine_y (
    .clk   (clk),
    .en    (en),
    .raw_x (x_in),
    .raw_y (y_in),
    .coef  (coef_y),
    .pos   (calc_y)
  );

  // output register: zero the position and pressure fields of a touch-up
  always_ff @(posedge clk) begin
    if (adv[NUM_STAGES-1]) begin
      event_kind <= kind_pipe[NUM_STAGES-2];
      if (kind_pipe[NUM_STAGES-2] == EV_UP) begin
        pos_x    <= '0;
        pos_y    <= '0;
        pressure <= '0;
      end else begin
        pos_x    <= calc_x;
        pos_y    <= calc_y;
        pressure <= pres_pipe[NUM_STAGES-2];
      end
    end
  end

  assign out_valid = vld[NUM_STAGES-1];

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
      !in_ready |-> (&vld) && !out_ready)
    else $error("input stalled with room in the pipeline");
  a_up_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && event_kind == EV_UP |-> pos_x == '0 && pos_y == '0 && pressure == '0)
    else $error("touch-up result carries non-zero fields");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y))
    else $error("stalled result changed");

endmodule
